>>> rtl/i2c_bit_level_master_assert.svh
// Assertion macros shared by the I2C bit-level master RTL.
`ifndef I2C_BIT_LEVEL_MASTER_ASSERT_SVH
`define I2C_BIT_LEVEL_MASTER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define I2CB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define I2CB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/i2cb_pkg.sv
// Types and constants of the I2C bit-level master.
package i2cb_pkg;

  // Width of the configuration register index.
  localparam int unsigned CfgIdxBits = 1;

  // Configuration register indexes.
  localparam logic [CfgIdxBits-1:0] CfgUnitTicks  = 1'b0;
  localparam logic [CfgIdxBits-1:0] CfgAckTimeout = 1'b1;

  // Command codes.
  localparam logic [2:0] CmdStart   = 3'd0;
  localparam logic [2:0] CmdStop    = 3'd1;
  localparam logic [2:0] CmdWrite   = 3'd2;
  localparam logic [2:0] CmdWaitAck = 3'd3;
  localparam logic [2:0] CmdRead    = 3'd4;

  // Delay lengths in units.
  localparam logic [2:0] UnitsOne  = 3'd1;
  localparam logic [2:0] UnitsTwo  = 3'd2;
  localparam logic [2:0] UnitsFour = 3'd4;

  // Number of data bits in a byte.
  localparam logic [3:0] BitsPerByte = 4'd8;

  // Sequencer phases, one-hot.
  typedef enum logic [13:0] {
    PH_IDLE    = 14'b00000000000001,
    PH_ST1     = 14'b00000000000010,
    PH_ST2     = 14'b00000000000100,
    PH_SP1     = 14'b00000000001000,
    PH_SP2     = 14'b00000000010000,
    PH_WA1     = 14'b00000000100000,
    PH_WA2     = 14'b00000001000000,
    PH_WB_HI   = 14'b00000010000000,
    PH_WB_LO   = 14'b00000100000000,
    PH_WB_NEXT = 14'b00001000000000,
    PH_RB_HI   = 14'b00010000000000,
    PH_RB_NEXT = 14'b00100000000000,
    PH_RA_HI   = 14'b01000000000000,
    PH_RA_LO   = 14'b10000000000000
  } phase_e;

  // One input item: one tick of the sequencer.
  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  // One result item.
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_failed;
  } res_t;

  // Configuration register contents.
  typedef struct packed {
    logic [15:0] unit_ticks;
    logic [15:0] ack_timeout;
  } cfg_t;

  // Sequencer state carried from tick to tick.
  typedef struct packed {
    phase_e      phase;
    logic [3:0]  bit_count;
    logic [7:0]  shift;
    logic [15:0] delay_count;
    logic [15:0] wait_count;
    logic [2:0]  units_left;
    logic        scl;
    logic        sda;
    logic        sda_oe;
    logic [7:0]  rx;
    logic        ack_fail;
    logic        ack_choice;
  } state_t;

  // State after reset: bus idle with both lines driven high.
  localparam state_t StateReset = '{
    phase:       PH_IDLE,
    bit_count:   4'd0,
    shift:       8'd0,
    delay_count: 16'd0,
    wait_count:  16'd0,
    units_left:  3'd0,
    scl:         1'b1,
    sda:         1'b1,
    sda_oe:      1'b1,
    rx:          8'd0,
    ack_fail:    1'b0,
    ack_choice:  1'b0
  };

  // Configuration values after reset.
  localparam cfg_t CfgReset = '{unit_ticks: 16'd100, ack_timeout: 16'd250};

endpackage

>>> rtl/i2cb_if.sv
// Valid/ready channel interfaces of the I2C bit-level master.

// Input item channel.
interface i2cb_item_if import i2cb_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Result item channel.
interface i2cb_res_if import i2cb_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Configuration write channel.
interface i2cb_cfg_if import i2cb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CfgIdxBits-1:0] index;
  logic [15:0]           wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> rtl/i2c_bit_level_master.sv
// Top level of the I2C bit-level master pin sequencer.
//
//   channel   direction  payload                                   transfer when
//   item_i    in         cmd_valid, cmd, tx_byte, send_ack, sda_in  valid & ready
//   res_o     out        scl/sda levels, drive, busy, done, rx, ack  valid & ready
//   cfg_i     in         index, wdata (unit_ticks, ack_timeout)      valid & ready
//
// One item is taken per cycle when the result side does not stall. An item is held
// in the input register, passes through one next-state pass of i2cb_step and
// lands in the result register, from which its result is offered.
// Reset leaves the sequencer idle with SCL and SDA driven high; there is no
// clearing pass. A stalled result holds the input register, and the input
// side keeps taking items as long as the input register can move on.
`include "i2c_bit_level_master_assert.svh"

module i2c_bit_level_master import i2cb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cb_item_if.sink   item_i,
  i2cb_res_if.source  res_o,
  i2cb_cfg_if.sink    cfg_i
);

  cfg_t   cfg;
  state_t state_q;
  state_t state_d;
  res_t   res_d;
  res_t   res_q;
  item_t  item_q;
  logic   item_valid_q;
  logic   res_valid_q;
  logic   res_free;
  logic   advance;

  // Configuration registers.
  i2cb_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Per-tick sequencer logic.
  i2cb_step u_step (
    .st_i   (state_q),
    .item_i (item_q),
    .cfg_i  (cfg),
    .st_o   (state_d),
    .res_o  (res_d)
  );

  // Handshake: the held item advances whenever the result register is free.
  assign res_free     = !res_valid_q || res_o.ready;
  assign advance      = item_valid_q && res_free;
  assign item_i.ready = !item_valid_q || res_free;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      item_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      item_q <= item_i.data;
    end
  end

  // Sequencer state moves only when an item is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  // Checks on the sequencer.
  `I2CB_ASSERT_NOW(a_done_not_busy, res_valid_q && res_q.done_res,
                   !res_q.busy_res, "done result still busy")
  `I2CB_ASSERT_NEXT(a_state_hold, !advance, $stable(state_q),
                    "state changed without an item")
  `I2CB_ASSERT_NOW(a_idle_clean, state_q.phase == PH_IDLE,
                   (state_q.units_left == 3'd0) && (state_q.delay_count == 16'd0),
                   "idle with a pending delay")
  `I2CB_ASSERT_NOW(a_units_range, 1'b1, state_q.units_left <= UnitsFour,
                   "delay length out of range")

endmodule

>>> rtl/i2cb_cfg.sv
// Configuration registers of the I2C bit-level master.
module i2cb_cfg import i2cb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cb_cfg_if.sink    cfg_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;

  // Writes are always taken.
  assign cfg_i.ready = 1'b1;

  // Register write on each completed transfer; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgUnitTicks:  cfg_q.unit_ticks  <= cfg_i.wdata;
        CfgAckTimeout: cfg_q.ack_timeout <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/i2cb_step.sv
// Next-state and result logic of the I2C pin sequencer for one tick.
module i2cb_step import i2cb_pkg::*; (
  input  state_t st_i,
  input  item_t  item_i,
  input  cfg_t   cfg_i,
  output state_t st_o,
  output res_t   res_o
);

  state_t      nxt;
  logic        done;
  logic        act;
  logic [15:0] unit;
  logic [3:0]  bit_inc;

  // A unit length of zero counts as one tick.
  assign unit    = (cfg_i.unit_ticks == 16'd0) ? 16'd1 : cfg_i.unit_ticks;
  assign bit_inc = st_i.bit_count + 4'd1;

  always_comb begin
    nxt  = st_i;
    done = 1'b0;
    act  = 1'b0;

    if (st_i.phase == PH_IDLE) begin
      // Idle: take a command; unknown codes leave the block idle.
      if (item_i.cmd_valid) begin
        case (item_i.cmd)
          CmdStart: begin
            nxt.sda_oe      = 1'b1;
            nxt.sda         = 1'b1;
            nxt.scl         = 1'b1;
            nxt.units_left  = UnitsFour;
            nxt.delay_count = 16'd0;
            nxt.phase       = PH_ST1;
          end
          CmdStop: begin
            nxt.sda_oe      = 1'b1;
            nxt.scl         = 1'b0;
            nxt.sda         = 1'b0;
            nxt.units_left  = UnitsFour;
            nxt.delay_count = 16'd0;
            nxt.phase       = PH_SP1;
          end
          CmdWrite: begin
            nxt.sda_oe      = 1'b1;
            nxt.scl         = 1'b0;
            nxt.bit_count   = 4'd0;
            nxt.sda         = item_i.tx_byte[7];
            nxt.shift       = {item_i.tx_byte[6:0], 1'b0};
            nxt.units_left  = UnitsTwo;
            nxt.delay_count = 16'd0;
            nxt.phase       = PH_WB_HI;
          end
          CmdWaitAck: begin
            nxt.sda_oe      = 1'b0;
            nxt.sda         = 1'b1;
            nxt.wait_count  = 16'd0;
            nxt.units_left  = UnitsOne;
            nxt.delay_count = 16'd0;
            nxt.phase       = PH_WA1;
          end
          CmdRead: begin
            nxt.sda_oe      = 1'b0;
            nxt.scl         = 1'b0;
            nxt.bit_count   = 4'd0;
            nxt.shift       = 8'd0;
            nxt.ack_choice  = item_i.send_ack;
            nxt.units_left  = UnitsTwo;
            nxt.delay_count = 16'd0;
            nxt.phase       = PH_RB_HI;
          end
          default: ;
        endcase
      end
    end else begin
      // Count down the pending delay; the phase action runs as it ends.
      act = 1'b1;
      if (st_i.units_left != 3'd0) begin
        act = 1'b0;
        if (({1'b0, st_i.delay_count} + 17'd1) >= {1'b0, unit}) begin
          nxt.delay_count = 16'd0;
          nxt.units_left  = st_i.units_left - 3'd1;
          act             = (st_i.units_left == 3'd1);
        end else begin
          nxt.delay_count = st_i.delay_count + 16'd1;
        end
      end

      // Phase action.
      if (act) begin
        case (st_i.phase)
          PH_ST1: begin
            nxt.sda         = 1'b0;
            nxt.units_left  = UnitsFour;
            nxt.delay_count = 16'd0;
            nxt.phase       = PH_ST2;
          end
          PH_ST2: begin
            nxt.scl = 1'b0;
            done    = 1'b1;
          end
          PH_SP1: begin
            nxt.scl         = 1'b1;
            nxt.sda         = 1'b1;
            nxt.units_left  = UnitsFour;
            nxt.delay_count = 16'd0;
            nxt.phase       = PH_SP2;
          end
          PH_SP2: done = 1'b1;
          PH_WA1: begin
            nxt.scl         = 1'b1;
            nxt.units_left  = UnitsOne;
            nxt.delay_count = 16'd0;
            nxt.phase       = PH_WA2;
          end
          PH_WA2: begin
            // Poll SDA every tick; a timeout runs a stop sequence.
            if (!item_i.sda_in) begin
              nxt.scl      = 1'b0;
              nxt.ack_fail = 1'b0;
              done         = 1'b1;
            end else if (st_i.wait_count >= cfg_i.ack_timeout) begin
              nxt.ack_fail    = 1'b1;
              nxt.sda_oe      = 1'b1;
              nxt.scl         = 1'b0;
              nxt.sda         = 1'b0;
              nxt.units_left  = UnitsFour;
              nxt.delay_count = 16'd0;
              nxt.phase       = PH_SP1;
            end else begin
              nxt.wait_count = st_i.wait_count + 16'd1;
            end
          end
          PH_WB_HI: begin
            nxt.scl         = 1'b1;
            nxt.units_left  = UnitsTwo;
            nxt.delay_count = 16'd0;
            nxt.phase       = PH_WB_LO;
          end
          PH_WB_LO: begin
            nxt.scl         = 1'b0;
            nxt.units_left  = UnitsTwo;
            nxt.delay_count = 16'd0;
            nxt.phase       = PH_WB_NEXT;
          end
          PH_WB_NEXT: begin
            nxt.bit_count = bit_inc;
            if (bit_inc >= BitsPerByte) begin
              done = 1'b1;
            end else begin
              nxt.sda         = st_i.shift[7];
              nxt.shift       = {st_i.shift[6:0], 1'b0};
              nxt.units_left  = UnitsTwo;
              nxt.delay_count = 16'd0;
              nxt.phase       = PH_WB_HI;
            end
          end
          PH_RB_HI: begin
            nxt.scl         = 1'b1;
            nxt.shift       = {st_i.shift[6:0], item_i.sda_in};
            nxt.units_left  = UnitsOne;
            nxt.delay_count = 16'd0;
            nxt.phase       = PH_RB_NEXT;
          end
          PH_RB_NEXT: begin
            nxt.bit_count   = bit_inc;
            nxt.scl         = 1'b0;
            nxt.units_left  = UnitsTwo;
            nxt.delay_count = 16'd0;
            if (bit_inc >= BitsPerByte) begin
              // Byte complete: drive the acknowledge bit.
              nxt.rx     = st_i.shift;
              nxt.sda_oe = 1'b1;
              nxt.sda    = !st_i.ack_choice;
              nxt.phase  = PH_RA_HI;
            end else begin
              nxt.phase  = PH_RB_HI;
            end
          end
          PH_RA_HI: begin
            nxt.scl         = 1'b1;
            nxt.units_left  = UnitsTwo;
            nxt.delay_count = 16'd0;
            nxt.phase       = PH_RA_LO;
          end
          PH_RA_LO: begin
            nxt.scl = 1'b0;
            done    = 1'b1;
          end
          default: done = 1'b1;
        endcase
      end

      // Sequence finished: back to idle.
      if (done) begin
        nxt.phase       = PH_IDLE;
        nxt.units_left  = 3'd0;
        nxt.delay_count = 16'd0;
      end
    end
  end

  assign st_o = nxt;

  // The result shows pins and status after this tick's update.
  assign res_o = '{
    scl_level:  nxt.scl,
    sda_level:  nxt.sda,
    sda_drive:  nxt.sda_oe,
    busy_res:   (nxt.phase != PH_IDLE),
    done_res:   done,
    rx_byte:    nxt.rx,
    ack_failed: nxt.ack_fail
  };

endmodule

>>> bench/i2c_bit_level_master_test.sv
// Self-checking testbench for the I2C bit-level master pin sequencer.
module i2c_bit_level_master_test import i2cb_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Command codes the block does not decode; it must stay idle on them.
  localparam logic [2:0] CmdUnusedFirst = 3'd5;
  localparam logic [2:0] CmdUnusedLast  = 3'd7;

  // Cycles to let pass after the last result, and the overall cycle budget.
  localparam int SettleCycles = 4;
  localparam int CycleLimit   = 3_000_000;

  // Random stimulus is spent in three stretches of at least this many ticks each.
  localparam int TicksPerStretch = 80;

  // Tracks the pin sequencer tick by tick and checks every result transfer.
  class pin_scoreboard;
    logic [15:0] unit_ticks;
    logic [15:0] ack_timeout;
    phase_e      phase;
    logic [3:0]  bit_count;
    logic [7:0]  shift;
    logic [15:0] delay_count;
    logic [15:0] wait_count;
    logic [2:0]  units_left;
    logic        scl;
    logic        sda;
    logic        sda_oe;
    logic [7:0]  rx;
    logic        ack_fail;
    logic        ack_choice;
    res_t        pins_due[$];
    int          mismatches;
    int          checked;
    int          completions;
    int          timeouts;

    function new();
      unit_ticks  = CfgReset.unit_ticks;
      ack_timeout = CfgReset.ack_timeout;
      phase       = PH_IDLE;
      bit_count   = '0;
      shift       = '0;
      delay_count = '0;
      wait_count  = '0;
      units_left  = '0;
      scl         = 1'b1;
      sda         = 1'b1;
      sda_oe      = 1'b1;
      rx          = '0;
      ack_fail    = 1'b0;
      ack_choice  = 1'b0;
      mismatches  = 0;
      checked     = 0;
      completions = 0;
      timeouts    = 0;
    endfunction

    // Ticks in one delay unit; a zero setting counts as one tick.
    function logic [16:0] span();
      return (unit_ticks == '0) ? 17'd1 : {1'b0, unit_ticks};
    endfunction

    // True when the next tick runs the action of the current phase.
    function bit acting_now();
      return phase != PH_IDLE && (units_left == '0 ||
             (units_left == 3'd1 && {1'b0, delay_count} + 17'd1 >= span()));
    endfunction

    function int pending();
      return pins_due.size();
    endfunction

    function void note_reg(logic [CfgIdxBits-1:0] index, logic [15:0] value);
      if (index == CfgUnitTicks) begin
        unit_ticks = value;
      end else begin
        ack_timeout = value;
      end
    endfunction

    function void hold(logic [2:0] units, phase_e next);
      units_left  = units;
      delay_count = '0;
      phase       = next;
    endfunction

    function void stop_bus();
      sda_oe = 1'b1;
      scl    = 1'b0;
      sda    = 1'b0;
      hold(UnitsFour, PH_SP1);
    endfunction

    function void shift_out();
      sda   = shift[7];
      shift = {shift[6:0], 1'b0};
      hold(UnitsTwo, PH_WB_HI);
    endfunction

    // Latches a command presented to the idle sequencer.
    function void take_cmd(item_t it);
      case (it.cmd)
        CmdStart: begin
          sda_oe = 1'b1;
          sda    = 1'b1;
          scl    = 1'b1;
          hold(UnitsFour, PH_ST1);
        end
        CmdStop: begin
          stop_bus();
        end
        CmdWrite: begin
          sda_oe    = 1'b1;
          scl       = 1'b0;
          bit_count = '0;
          shift     = it.tx_byte;
          shift_out();
        end
        CmdWaitAck: begin
          sda_oe     = 1'b0;
          sda        = 1'b1;
          wait_count = '0;
          hold(UnitsOne, PH_WA1);
        end
        CmdRead: begin
          sda_oe     = 1'b0;
          scl        = 1'b0;
          bit_count  = '0;
          shift      = '0;
          ack_choice = it.send_ack;
          hold(UnitsTwo, PH_RB_HI);
        end
        default: begin
        end
      endcase
    endfunction

    // Runs the pin action that ends a wait; returns 1 when the sequence is over.
    function bit run_phase(logic sda_in);
      case (phase)
        PH_ST1: begin
          sda = 1'b0;
          hold(UnitsFour, PH_ST2);
          return 1'b0;
        end
        PH_ST2: begin
          scl = 1'b0;
          return 1'b1;
        end
        PH_SP1: begin
          scl = 1'b1;
          sda = 1'b1;
          hold(UnitsFour, PH_SP2);
          return 1'b0;
        end
        PH_SP2: return 1'b1;
        PH_WA1: begin
          scl = 1'b1;
          hold(UnitsOne, PH_WA2);
          return 1'b0;
        end
        PH_WA2: begin
          // The slave pulls SDA low to acknowledge; a high line is polled
          // until the timeout, after which the bus is released with a stop.
          if (!sda_in) begin
            scl      = 1'b0;
            ack_fail = 1'b0;
            return 1'b1;
          end
          if (wait_count >= ack_timeout) begin
            ack_fail = 1'b1;
            timeouts++;
            stop_bus();
            return 1'b0;
          end
          wait_count = wait_count + 16'd1;
          return 1'b0;
        end
        PH_WB_HI: begin
          scl = 1'b1;
          hold(UnitsTwo, PH_WB_LO);
          return 1'b0;
        end
        PH_WB_LO: begin
          scl = 1'b0;
          hold(UnitsTwo, PH_WB_NEXT);
          return 1'b0;
        end
        PH_WB_NEXT: begin
          bit_count = bit_count + 4'd1;
          if (bit_count >= BitsPerByte) return 1'b1;
          shift_out();
          return 1'b0;
        end
        PH_RB_HI: begin
          scl   = 1'b1;
          shift = {shift[6:0], sda_in};
          hold(UnitsOne, PH_RB_NEXT);
          return 1'b0;
        end
        PH_RB_NEXT: begin
          bit_count = bit_count + 4'd1;
          scl       = 1'b0;
          if (bit_count >= BitsPerByte) begin
            // Byte complete: drive ACK (low) or NACK (high) for the slave.
            rx     = shift;
            sda_oe = 1'b1;
            sda    = !ack_choice;
            hold(UnitsTwo, PH_RA_HI);
          end else begin
            hold(UnitsTwo, PH_RB_HI);
          end
          return 1'b0;
        end
        PH_RA_HI: begin
          scl = 1'b1;
          hold(UnitsTwo, PH_RA_LO);
          return 1'b0;
        end
        PH_RA_LO: begin
          scl = 1'b0;
          return 1'b1;
        end
        default: return 1'b1;
      endcase
    endfunction

    // Advances the sequencer by one accepted tick and queues its pin levels.
    function void note_tick(item_t it);
      res_t want;
      bit   finished;
      bit   act;
      finished = 1'b0;
      if (phase == PH_IDLE) begin
        if (it.cmd_valid) take_cmd(it);
      end else begin
        act = 1'b1;
        if (units_left != '0) begin
          act = 1'b0;
          if ({1'b0, delay_count} + 17'd1 >= span()) begin
            delay_count = '0;
            units_left  = units_left - 3'd1;
            if (units_left == '0) act = 1'b1;
          end else begin
            delay_count = delay_count + 16'd1;
          end
        end
        if (act && run_phase(it.sda_in)) begin
          phase       = PH_IDLE;
          units_left  = '0;
          delay_count = '0;
          finished    = 1'b1;
          completions++;
        end
      end
      want.scl_level  = scl;
      want.sda_level  = sda;
      want.sda_drive  = sda_oe;
      want.busy_res   = (phase != PH_IDLE);
      want.done_res   = finished;
      want.rx_byte    = rx;
      want.ack_failed = ack_fail;
      pins_due.push_back(want);
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
        mismatches++;
      end
    endfunction

    // Checks one result transfer against the oldest prediction.
    function void check_pins(res_t got);
      res_t want;
      if (pins_due.size() == 0) begin
        $display("%0t ns: result %h arrived with no prediction waiting", $time, got);
        mismatches++;
        return;
      end
      want = pins_due.pop_front();
      checked++;
      compare("scl_level", want.scl_level, got.scl_level);
      compare("sda_level", want.sda_level, got.sda_level);
      compare("sda_drive", want.sda_drive, got.sda_drive);
      compare("busy_res", want.busy_res, got.busy_res);
      compare("done_res", want.done_res, got.done_res);
      compare("rx_byte", want.rx_byte, got.rx_byte);
      compare("ack_failed", want.ack_failed, got.ack_failed);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  i2cb_item_if item_ch ();
  i2cb_res_if  res_ch ();
  i2cb_cfg_if  cfg_ch ();

  i2c_bit_level_master dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  pin_scoreboard sb = new();
  int gap_pct;
  int stall_pct;
  int ticks_sent;
  int cycles;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver: ready is redrawn at every falling edge.
  initial res_ch.ready = 1'b0;
  always @(negedge clk_i) begin
    res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Every result transfer is checked at the rising edge that completes it.
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) sb.check_pins(res_ch.data);
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Run exceeded %0d cycles with %0d results outstanding.",
               CycleLimit, sb.pending());
      $display("[i2c_bit_level_master] ERROR");
      $finish;
    end
  end

  // Presents one tick, with random gaps first, and notes it once transferred.
  task automatic put_tick(item_t it);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < gap_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    do @(posedge clk_i); while (!item_ch.ready);
    sb.note_tick(it);
    ticks_sent++;
  endtask

  task automatic idle_ticks(int count);
    item_t it;
    repeat (count) begin
      it           = item_t'($urandom());
      it.cmd_valid = 1'b0;
      put_tick(it);
    end
  endtask

  // Issues one command and feeds ticks until the sequencer is idle again.
  // The first high_polls acknowledge polls see SDA high, later ones see it
  // low; sda_fill sets SDA on the other busy ticks (0, 1, or 2 for random).
  task automatic run_cmd(logic [2:0] code, logic [7:0] tx, logic ack,
                         int high_polls, int sda_fill);
    item_t it;
    int    polls;
    polls        = 0;
    it.cmd_valid = 1'b1;
    it.cmd       = code;
    it.tx_byte   = tx;
    it.send_ack  = ack;
    it.sda_in    = 1'($urandom_range(0, 1));
    put_tick(it);
    while (sb.phase != PH_IDLE) begin
      // Now and then a command arrives while busy; it must be ignored.
      it.cmd_valid = ($urandom_range(0, 9) == 0);
      it.cmd       = 3'($urandom_range(0, 7));
      it.tx_byte   = 8'($urandom_range(0, 255));
      it.send_ack  = 1'($urandom_range(0, 1));
      if (sb.phase == PH_WA2 && sb.acting_now()) begin
        it.sda_in = (polls < high_polls);
        polls++;
      end else if (sda_fill > 1) begin
        it.sda_in = 1'($urandom_range(0, 1));
      end else begin
        it.sda_in = sda_fill[0];
      end
      put_tick(it);
    end
  endtask

  // Brings the sequencer to idle, then holds the input until all results are in.
  task automatic settle();
    while (sb.phase != PH_IDLE) idle_ticks(1);
    @(negedge clk_i);
    item_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [CfgIdxBits-1:0] index, logic [15:0] value);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.wdata <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.note_reg(index, value);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_idling(int sender_pct, int receiver_pct);
    gap_pct   = sender_pct;
    stall_pct = receiver_pct;
  endtask

  // Mostly a well-formed bus transaction with random content, else one
  // command on its own in any order.
  task automatic random_transaction();
    int polls_max;
    polls_max = int'(sb.ack_timeout) + 2;
    if ($urandom_range(0, 99) < 80) begin
      run_cmd(CmdStart, 8'($urandom()), 1'($urandom()), 0, 2);
      run_cmd(CmdWrite, 8'($urandom()), 1'($urandom()), 0, 2);
      run_cmd(CmdWaitAck, 8'($urandom()), 1'($urandom()),
              $urandom_range(0, polls_max), 2);
      repeat ($urandom_range(0, 2)) begin
        if ($urandom_range(0, 1) == 0) begin
          run_cmd(CmdWrite, 8'($urandom()), 1'($urandom()), 0, 2);
          run_cmd(CmdWaitAck, 8'($urandom()), 1'($urandom()),
                  $urandom_range(0, polls_max), 2);
        end else begin
          run_cmd(CmdRead, 8'($urandom()), 1'($urandom()), 0, 2);
        end
      end
      run_cmd(CmdStop, 8'($urandom()), 1'($urandom()), 0, 2);
    end else begin
      run_cmd(3'($urandom_range(0, 7)), 8'($urandom()), 1'($urandom()),
              $urandom_range(0, polls_max), 2);
    end
    idle_ticks($urandom_range(0, 3));
  endtask

  task automatic random_stretch();
    int goal;
    settle();
    set_reg(CfgUnitTicks, 16'($urandom_range(0, 3)));
    set_reg(CfgAckTimeout, 16'($urandom_range(0, 6)));
    goal = ticks_sent + TicksPerStretch;
    while (ticks_sent < goal) random_transaction();
  endtask

  // Main sequence: reset, directed cases, random stretches, long settings.
  initial begin
    rst_ni         = 1'b0;
    item_ch.valid  = 1'b0;
    item_ch.data   = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = '0;
    cfg_ch.wdata   = '0;
    gap_pct        = 23;
    stall_pct      = 76;
    ticks_sent     = 0;
    cycles         = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Undecoded commands leave the block idle; then an acknowledge with the
    // delay setting left by reset.
    idle_ticks(3);
    for (int c = CmdUnusedFirst; c <= CmdUnusedLast; c++) begin
      run_cmd(3'(c), 8'hFF, 1'b1, 0, 2);
    end
    run_cmd(CmdWaitAck, 8'h00, 1'b0, 0, 2);

    // Zero settings: one tick per unit, and the first high poll fails.
    settle();
    set_reg(CfgUnitTicks, 16'd0);
    set_reg(CfgAckTimeout, 16'd0);
    run_cmd(CmdStart, 8'h00, 1'b0, 0, 2);
    run_cmd(CmdWrite, 8'h00, 1'b0, 0, 0);
    run_cmd(CmdWrite, 8'hFF, 1'b1, 0, 1);
    run_cmd(CmdWaitAck, 8'h00, 1'b0, 0, 2);
    run_cmd(CmdWaitAck, 8'h00, 1'b0, 1, 2);
    run_cmd(CmdRead, 8'h00, 1'b1, 0, 0);
    run_cmd(CmdRead, 8'h00, 1'b0, 0, 1);
    run_cmd(CmdRead, 8'h00, 1'b1, 0, 2);
    run_cmd(CmdStop, 8'h00, 1'b0, 0, 2);

    // Acknowledge arriving on the last allowed poll, and one poll too late.
    settle();
    set_reg(CfgUnitTicks, 16'd1);
    set_reg(CfgAckTimeout, 16'd3);
    run_cmd(CmdStart, 8'h00, 1'b0, 0, 2);
    run_cmd(CmdWrite, 8'hA5, 1'b0, 0, 2);
    run_cmd(CmdWaitAck, 8'h00, 1'b0, 3, 2);
    run_cmd(CmdWaitAck, 8'h00, 1'b0, 4, 2);
    run_cmd(CmdRead, 8'h00, 1'b1, 0, 2);
    run_cmd(CmdStop, 8'h00, 1'b0, 0, 2);

    // Random stretches under three idling patterns.
    random_stretch();
    set_idling(76, 23);
    random_stretch();
    set_idling(0, 0);
    random_stretch();

    // Largest acknowledge timeout: a few high polls are well inside it.
    settle();
    set_reg(CfgUnitTicks, 16'd1);
    set_reg(CfgAckTimeout, 16'hFFFF);
    run_cmd(CmdWaitAck, 8'h00, 1'b0, 5, 2);

    // Drain the last results and report.
    @(negedge clk_i);
    item_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    $display("Sent %0d sequencer ticks and checked %0d results with %0d mismatches.",
             ticks_sent, sb.checked, sb.mismatches);
    $display("Predicted %0d completed sequences and %0d acknowledge timeouts.",
             sb.completions, sb.timeouts);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[i2c_bit_level_master] OK");
    end else begin
      $display("[i2c_bit_level_master] ERROR");
    end
    $finish;
  end

endmodule
